// File: sv/quadratic_root_solver_top_defines.svh
// assertion macros for the quadratic root solver
// used by the files that check the queue and the result port
`ifndef QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`ifndef SYNTH
`define QRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("qrs check failed");
`define QRS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("qrs reset check failed");
`else
`define QRS_ASSERT(lbl, prop)
`define QRS_ASSERT_RST(lbl, prop)
`endif
`endif

// File: sv/qrs_pkg.sv
// shared constants and types of the quadratic root solver
// no dependencies
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_WIDTH      = 34;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0] cnt;
    logic       degen;
  } ctl_t;
endpackage

// File: sv/quadratic_root_solver_top.sv
// quadratic root solver top: front end, queue, square root and two dividers
// depends on qrs_pkg, qrs_front, qrs_fifo, qrs_sqrt, qrs_div and the defines header
//
//  port group     direction  handshake          payload
//  command        in         start / busy       coef_a, coef_b, coef_c
//  result         out        strobe, one cycle  root_count, first_root, second_root, degenerate
//
// one item per cycle while busy is low; the square root and the dividers are bit-per-stage
// pipelines, one result bit per stage. reset is synchronous and clears control only.
// busy counts the queue plus the two front stages against four entries; the queue is
// popped every cycle, so at most three are held and busy stays low in practice;
// the back pipeline never stalls, so a result is on the ports exactly one cycle.
`timescale 1ns / 1ps
`include "quadratic_root_solver_top_defines.svh"
module quadratic_root_solver_top #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COEF_WIDTH-1:0]          coef_a,
  input  logic signed [COEF_WIDTH-1:0]          coef_b,
  input  logic signed [COEF_WIDTH-1:0]          coef_c,
  output logic                                  strobe,
  output logic [1:0]                            root_count,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]  first_root,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]  second_root,
  output logic                                  degenerate
);
  localparam int W     = COEF_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DEPTH = qrs_pkg::QUEUE_DEPTH;
  localparam int LW    = $clog2(DEPTH+1);
  localparam int DW    = 2*W+2;
  localparam int NBW   = W+F+1;
  localparam int DENW  = W+1;
  localparam int SW    = (DW+2*F)/2;
  localparam int NW    = W+F+3;
  localparam int CTLW  = $bits(qrs_pkg::ctl_t);
  localparam int TAGW  = CTLW + NBW + DENW;
  localparam int EW    = TAGW + DW;
  localparam int OW    = qrs_pkg::OUT_WIDTH;

  logic                   push, pop, empty;
  logic [LW-1:0]          level;
  qrs_pkg::ctl_t          f_ctl;
  logic [DW-1:0]          f_disc;
  logic signed [NBW-1:0]  f_nb;
  logic signed [DENW-1:0] f_den;
  logic [EW-1:0]          q_wr, q_rd;

  logic                   s_valid;
  logic [SW-1:0]          s_root;
  logic [TAGW-1:0]        s_tag;
  logic signed [NBW-1:0]  s_nb;
  logic signed [NW-1:0]   s_ext;

  logic                   m_valid;
  logic signed [NW-1:0]   m_n1, m_n2;
  logic signed [DENW-1:0] m_den;
  qrs_pkg::ctl_t          m_ctl;

  logic                   d1_valid, d2_valid;
  logic [OW-1:0]          d1_q, d2_q;
  logic [CTLW-1:0]        d1_tag, d2_tag;
  qrs_pkg::ctl_t          o_ctl;

  qrs_front #(.W(W), .F(F), .DEPTH(DEPTH)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .level(level), .push(push), .ctl(f_ctl), .disc(f_disc), .nb(f_nb), .den(f_den)
  );

  assign q_wr = {f_ctl, f_nb, f_den, f_disc};
  assign pop  = !empty;

  qrs_fifo #(.EW(EW), .DEPTH(DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wr_data(q_wr), .pop(pop),
    .rd_data(q_rd), .empty(empty), .count(level)
  );

  qrs_sqrt #(.RW(DW), .FB(F), .TAGW(TAGW)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(pop), .radicand(q_rd[DW-1:0]),
    .tag_in(q_rd[EW-1:DW]), .out_valid(s_valid), .root(s_root), .tag_out(s_tag)
  );

  assign s_nb  = s_tag[NBW+DENW-1:DENW];
  assign s_ext = $signed({{(NW-SW){1'b0}}, s_root});

  // numerators -b*2^F + s and -b*2^F - s
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= s_valid;
    end
    m_n1  <= NW'(s_nb) + s_ext;
    m_n2  <= NW'(s_nb) - s_ext;
    m_den <= s_tag[DENW-1:0];
    m_ctl <= s_tag[TAGW-1:NBW+DENW];
  end

  qrs_div #(.NW(NW), .DENW(DENW), .TAGW(CTLW)) u_div1 (
    .clk(clk), .rst(rst), .in_valid(m_valid), .num(m_n1), .den(m_den),
    .tag_in(m_ctl), .out_valid(d1_valid), .quot(d1_q), .tag_out(d1_tag)
  );

  qrs_div #(.NW(NW), .DENW(DENW), .TAGW(CTLW)) u_div2 (
    .clk(clk), .rst(rst), .in_valid(m_valid), .num(m_n2), .den(m_den),
    .tag_in(m_ctl), .out_valid(d2_valid), .quot(d2_q), .tag_out(d2_tag)
  );

  assign o_ctl = d1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= d1_valid && d2_valid;
    end
    degenerate  <= o_ctl.degen;
    root_count  <= o_ctl.degen ? qrs_pkg::CNT_NONE : o_ctl.cnt;
    first_root  <= (!o_ctl.degen && o_ctl.cnt != qrs_pkg::CNT_NONE) ? d1_q : '0;
    second_root <= (!o_ctl.degen && o_ctl.cnt == qrs_pkg::CNT_TWO && d2_tag == d1_tag) ?
                   d2_q : '0;
  end

  `QRS_ASSERT(a_lanes_aligned, d1_valid == d2_valid)
  `QRS_ASSERT(a_degen_clear, (strobe && degenerate) |-> root_count == qrs_pkg::CNT_NONE && first_root == '0)
  `QRS_ASSERT(a_single_root, (strobe && root_count != qrs_pkg::CNT_TWO) |-> second_root == '0)
  `QRS_ASSERT_RST(a_reset_quiet, rst |=> !strobe)
endmodule

// File: sv/qrs_front.sv
// front end: takes coefficients, forms b*b and a*c, classifies the discriminant
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_front #(
  parameter int W     = qrs_pkg::COEF_WIDTH_DEF,
  parameter int F     = qrs_pkg::FRAC_BITS_DEF,
  parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [W-1:0]              coef_a,
  input  logic signed [W-1:0]              coef_b,
  input  logic signed [W-1:0]              coef_c,
  input  logic [$clog2(DEPTH+1)-1:0]       level,
  output logic                             push,
  output qrs_pkg::ctl_t                    ctl,
  output logic [2*W+1:0]                   disc,
  output logic signed [W+F:0]              nb,
  output logic signed [W:0]                den
);
  localparam int LW  = $clog2(DEPTH+1);
  localparam int DW  = 2*W+2;
  localparam int NBW = W+F+1;

  logic                acc;
  logic                v1, v2;
  logic signed [W-1:0] a_q, b_q, c_q;
  logic [W-1:0]        a_mag, b_mag, c_mag;
  logic [2*W-1:0]      bb_q, ac_q;
  logic                acneg_q, azero_q;
  logic signed [W-1:0] a_r, b_r;
  logic [DW-1:0]       p4, b2x;
  logic signed [NBW-1:0] bext;

  // credits: queue entries plus beats still in the two front stages
  assign busy = ((LW+1)'(level) + (LW+1)'(v1) + (LW+1)'(v2)) >= (LW+1)'(DEPTH);
  assign acc  = start && !busy;

  assign a_mag = a_q[W-1] ? (~a_q + 1'b1) : a_q;
  assign b_mag = b_q[W-1] ? (~b_q + 1'b1) : b_q;
  assign c_mag = c_q[W-1] ? (~c_q + 1'b1) : c_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
    end
    if (acc) begin
      a_q <= coef_a;
      b_q <= coef_b;
      c_q <= coef_c;
    end
    bb_q    <= b_mag * b_mag;
    ac_q    <= a_mag * c_mag;
    acneg_q <= (a_q[W-1] != c_q[W-1]) && (c_q != '0);
    azero_q <= (a_q == '0);
    a_r     <= a_q;
    b_r     <= b_q;
  end

  assign p4  = {ac_q, 2'b00};
  assign b2x = {2'b00, bb_q};

  always_comb begin
    ctl.degen = azero_q;
    ctl.cnt   = qrs_pkg::CNT_NONE;
    disc      = '0;
    if (acneg_q) begin
      disc    = b2x + p4;
      ctl.cnt = qrs_pkg::CNT_TWO;
    end else if (b2x >= p4) begin
      disc    = b2x - p4;
      ctl.cnt = (b2x == p4) ? qrs_pkg::CNT_ONE : qrs_pkg::CNT_TWO;
    end
  end

  assign bext = NBW'(b_r);
  assign nb   = (-bext) <<< F;
  assign den  = {a_r, 1'b0};
  assign push = v2;
endmodule

// File: sv/qrs_fifo.sv
// short register queue between the front end and the root pipeline
// depends on quadratic_root_solver_top_defines.svh
`timescale 1ns / 1ps
`include "quadratic_root_solver_top_defines.svh"
module qrs_fifo #(
  parameter int EW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [EW-1:0]              wr_data,
  input  logic                       pop,
  output logic [EW-1:0]              rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [EW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `QRS_ASSERT(a_no_overflow, push |-> (count < LW'(DEPTH)) || pop)
  `QRS_ASSERT(a_no_underflow, pop |-> !empty)
  `QRS_ASSERT(a_drain, (pop && !push) |=> count == $past(count) - 1'b1)
  `QRS_ASSERT_RST(a_reset_empty, rst |=> count == '0)
endmodule

// File: sv/qrs_sqrt.sv
// pipelined integer square root of radicand * 2^(2*FB), one result bit per stage
// no dependencies
`timescale 1ns / 1ps
module qrs_sqrt #(
  parameter int RW   = 34,
  parameter int FB   = 16,
  parameter int TAGW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [RW-1:0]                radicand,
  input  logic [TAGW-1:0]              tag_in,
  output logic                         out_valid,
  output logic [(RW+2*FB)/2-1:0]       root,
  output logic [TAGW-1:0]              tag_out
);
  localparam int VW  = RW + 2*FB;
  localparam int SW  = VW / 2;
  localparam int RMW = SW + 2;

  logic [VW-1:0]   v_q   [SW+1];
  logic [RMW-1:0]  rem_q [SW+1];
  logic [SW-1:0]   rt_q  [SW+1];
  logic [TAGW-1:0] tg_q  [SW+1];
  logic            vl_q  [SW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_q[0] <= 1'b0;
    end else begin
      vl_q[0] <= in_valid;
    end
    v_q[0]   <= {radicand, {(2*FB){1'b0}}};
    rem_q[0] <= '0;
    rt_q[0]  <= '0;
    tg_q[0]  <= tag_in;
  end

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic [RMW-1:0] cur, trial;
    assign cur   = {rem_q[i][RMW-3:0], v_q[i][VW-1:VW-2]};
    assign trial = {rt_q[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        vl_q[i+1] <= 1'b0;
      end else begin
        vl_q[i+1] <= vl_q[i];
      end
      v_q[i+1]  <= v_q[i] << 2;
      tg_q[i+1] <= tg_q[i];
      if (cur >= trial) begin
        rem_q[i+1] <= cur - trial;
        rt_q[i+1]  <= {rt_q[i][SW-2:0], 1'b1};
      end else begin
        rem_q[i+1] <= cur;
        rt_q[i+1]  <= {rt_q[i][SW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vl_q[SW];
  assign root      = rt_q[SW];
  assign tag_out   = tg_q[SW];
endmodule

// File: sv/qrs_div.sv
// pipelined signed divide, truncated toward zero, saturated to the output width
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_div #(
  parameter int NW   = 35,
  parameter int DENW = 17,
  parameter int TAGW = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [NW-1:0]              num,
  input  logic signed [DENW-1:0]            den,
  input  logic [TAGW-1:0]                   tag_in,
  output logic                              out_valid,
  output logic [qrs_pkg::OUT_WIDTH-1:0]     quot,
  output logic [TAGW-1:0]                   tag_out
);
  localparam int OW = qrs_pkg::OUT_WIDTH;
  localparam int QX = (NW > OW) ? NW : OW + 1;
  localparam logic [QX-1:0] LIMN = QX'(1) << (OW-1);
  localparam logic [QX-1:0] LIMP = LIMN - 1'b1;

  logic [NW-1:0]   n_q  [NW+1];
  logic [NW-1:0]   q_q  [NW+1];
  logic [DENW-1:0] r_q  [NW+1];
  logic [DENW-1:0] d_q  [NW+1];
  logic            ng_q [NW+1];
  logic [TAGW-1:0] tg_q [NW+1];
  logic            vl_q [NW+1];

  logic [QX-1:0]   qx, posv, negm, negv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_q[0] <= 1'b0;
    end else begin
      vl_q[0] <= in_valid;
    end
    n_q[0]  <= num[NW-1] ? (~num + 1'b1) : num;
    d_q[0]  <= den[DENW-1] ? (~den + 1'b1) : den;
    ng_q[0] <= num[NW-1] != den[DENW-1];
    q_q[0]  <= '0;
    r_q[0]  <= '0;
    tg_q[0] <= tag_in;
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DENW:0] cur;
    assign cur = {r_q[i], n_q[i][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vl_q[i+1] <= 1'b0;
      end else begin
        vl_q[i+1] <= vl_q[i];
      end
      n_q[i+1]  <= n_q[i] << 1;
      d_q[i+1]  <= d_q[i];
      ng_q[i+1] <= ng_q[i];
      tg_q[i+1] <= tg_q[i];
      if (cur >= {1'b0, d_q[i]}) begin
        r_q[i+1] <= DENW'(cur - {1'b0, d_q[i]});
        q_q[i+1] <= {q_q[i][NW-2:0], 1'b1};
      end else begin
        r_q[i+1] <= cur[DENW-1:0];
        q_q[i+1] <= {q_q[i][NW-2:0], 1'b0};
      end
    end
  end

  assign qx   = QX'(q_q[NW]);
  assign posv = (qx > LIMP) ? LIMP : qx;
  assign negm = (qx > LIMN) ? LIMN : qx;
  assign negv = '0 - negm;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vl_q[NW];
    end
    quot    <= ng_q[NW] ? negv[OW-1:0] : posv[OW-1:0];
    tag_out <= tg_q[NW];
  end
endmodule
